// ----- design/rfc_pkg.sv -----
`default_nettype none

package rfc_pkg;

   // Default sizes of the forest and of the observation.
   localparam int DEF_MAX_TREES    = 64;
   localparam int DEF_MAX_NODES    = 256;
   localparam int DEF_MAX_FEATURES = 64;
   localparam int DEF_NUM_CLASSES  = 10;

   // Depth of the command queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Largest vote count that fits the result word.
   localparam int VOTE_SAT = 127;

   // Command codes of the input word, also used as queue operation codes.
   localparam logic [1:0] CMD_NODE     = 2'd0;
   localparam logic [1:0] CMD_FEATURE  = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;

   // One stored tree node.
   typedef struct packed {
      logic              leaf;
      logic [5:0]        feat;
      logic [3:0]        cls;
      logic signed [23:0] cut;
      logic [7:0]        lo;
      logic [7:0]        hi;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   // One queued operation handed from front to back.
   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         tree;
      logic [7:0]         node;
      node_type           node_data;
      logic [5:0]         feat_idx;
      logic signed [15:0] feat_val;
   } entry_type;

endpackage

`default_nettype wire

// ----- design/random_forest_classifier.sv -----
// Node and feature writes pass through the queue and reach memory when the idle back takes them.
// A classify word walks every tree in use from its root, then scans the class counts for its result;
// each inner node costs a node read and a feature read.
// One word is executed at a time; up to four words wait in the queue, one result waits at rsp.
// Reset (synchronous) empties the queue and the result register and sets num_trees to 1;
// the node and feature memories are not cleared and hold nothing valid until written.
`default_nettype none

module random_forest_classifier
   import rfc_pkg::*;
#(
   parameter int MAX_TREES    = DEF_MAX_TREES,
   parameter int MAX_NODES    = DEF_MAX_NODES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output      logic               req_full,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [5:0]         req_tree_index,
   input  wire logic [7:0]         req_node_index,
   input  wire logic               req_is_leaf,
   input  wire logic [5:0]         req_split_feature,
   input  wire logic signed [23:0] req_threshold,
   input  wire logic [7:0]         req_left_child,
   input  wire logic [7:0]         req_right_child,
   input  wire logic [3:0]         req_leaf_class,
   input  wire logic [5:0]         req_feature_index,
   input  wire logic signed [15:0] req_feature_value,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop,
   output      logic [3:0]         rsp_predicted_class,
   output      logic [6:0]         rsp_winning_votes,
   output      logic               rsp_walk_error,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [6:0]         csr_num_trees
);

   logic [6:0] num_trees_ff;
   logic       q_valid;
   logic       q_pop;
   entry_type  q_entry;

   // Tree count register; always ready to take a word.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_trees_ff <= 7'd1;
      end else if (csr_valid && csr_ready) begin
         num_trees_ff <= csr_num_trees;
      end
   end

   rfc_front #(
      .MAX_TREES   (MAX_TREES),
      .MAX_NODES   (MAX_NODES),
      .MAX_FEATURES(MAX_FEATURES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_tree_index   (req_tree_index),
      .req_node_index   (req_node_index),
      .req_is_leaf      (req_is_leaf),
      .req_split_feature(req_split_feature),
      .req_threshold    (req_threshold),
      .req_left_child   (req_left_child),
      .req_right_child  (req_right_child),
      .req_leaf_class   (req_leaf_class),
      .req_feature_index(req_feature_index),
      .req_feature_value(req_feature_value),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_entry          (q_entry)
   );

   rfc_back #(
      .MAX_TREES   (MAX_TREES),
      .MAX_NODES   (MAX_NODES),
      .MAX_FEATURES(MAX_FEATURES),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .num_trees          (num_trees_ff),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_entry            (q_entry),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_predicted_class(rsp_predicted_class),
      .rsp_winning_votes  (rsp_winning_votes),
      .rsp_walk_error     (rsp_walk_error)
   );

endmodule

`default_nettype wire

// ----- design/rfc_ram.sv -----
`default_nettype none

module rfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/rfc_front.sv -----
`default_nettype none

module rfc_front
   import rfc_pkg::*;
#(
   parameter int MAX_TREES    = DEF_MAX_TREES,
   parameter int MAX_NODES    = DEF_MAX_NODES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output      logic               req_full,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [5:0]         req_tree_index,
   input  wire logic [7:0]         req_node_index,
   input  wire logic               req_is_leaf,
   input  wire logic [5:0]         req_split_feature,
   input  wire logic signed [23:0] req_threshold,
   input  wire logic [7:0]         req_left_child,
   input  wire logic [7:0]         req_right_child,
   input  wire logic [3:0]         req_leaf_class,
   input  wire logic [5:0]         req_feature_index,
   input  wire logic signed [15:0] req_feature_value,
   output      logic               q_valid,
   input  wire logic               q_pop,
   output      entry_type          q_entry
);

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   logic              keep;
   logic              push_q;
   logic              pop_q;
   entry_type         entry;

   assign req_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign q_valid  = (count_ff != '0);
   assign q_entry  = entries_ff[rd_ptr_ff];

   // Decode the word: drop out-of-range writes and unused commands.
   always_comb begin
      keep = 1'b0;
      case (req_cmd)
         CMD_NODE:     keep = (32'(req_tree_index) < MAX_TREES) &&
                              (32'(req_node_index) < MAX_NODES);
         CMD_FEATURE:  keep = (32'(req_feature_index) < MAX_FEATURES);
         CMD_CLASSIFY: keep = 1'b1;
         default:      keep = 1'b0;
      endcase
   end

   // Pack the fields into one queue entry.
   always_comb begin
      entry.op             = req_cmd;
      entry.tree           = req_tree_index;
      entry.node           = req_node_index;
      entry.node_data.leaf = req_is_leaf;
      entry.node_data.feat = req_split_feature;
      entry.node_data.cls  = req_leaf_class;
      entry.node_data.cut  = req_threshold;
      entry.node_data.lo   = req_left_child;
      entry.node_data.hi   = req_right_child;
      entry.feat_idx       = req_feature_index;
      entry.feat_val       = req_feature_value;
   end

   // Queue pointer and fill count updates.
   always_comb begin
      push_q    = accept && keep;
      pop_q     = q_pop && q_valid;
      wr_ptr_in = push_q ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_q ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_q && !pop_q) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_q && !push_q) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ----- design/rfc_back.sv -----
`default_nettype none

module rfc_back
   import rfc_pkg::*;
#(
   parameter int MAX_TREES    = DEF_MAX_TREES,
   parameter int MAX_NODES    = DEF_MAX_NODES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int NUM_CLASSES  = DEF_NUM_CLASSES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] num_trees,
   input  wire logic       q_valid,
   output      logic       q_pop,
   input  wire entry_type  q_entry,
   output      logic       rsp_empty,
   input  wire logic       rsp_pop,
   output      logic [3:0] rsp_predicted_class,
   output      logic [6:0] rsp_winning_votes,
   output      logic       rsp_walk_error
);

   localparam int TREE_W  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int FEAT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CLASS_W = $clog2(NUM_CLASSES);
   localparam int CNT_W   = $clog2(MAX_TREES + 1);
   localparam int NADDR_W = TREE_W + NODE_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NODE = 3'd1;
   localparam logic [2:0] S_FEAT = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   tree_ff, tree_in;
   logic [CNT_W-1:0]   trees_ff, trees_in;
   logic [NODE_W-1:0]  visits_ff, visits_in;
   node_type           node_ff, node_in;
   logic               feat_ok_ff, feat_ok_in;
   logic               err_ff, err_in;
   logic [CNT_W-1:0]   counts_ff [NUM_CLASSES];
   logic [CNT_W-1:0]   counts_in [NUM_CLASSES];
   logic [CLASS_W-1:0] scan_ff, scan_in;
   logic [CLASS_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]   best_votes_ff, best_votes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_class_ff, rsp_class_in;
   logic [6:0]         rsp_votes_ff, rsp_votes_in;
   logic               rsp_err_ff, rsp_err_in;

   logic                 node_wr_en;
   logic [NADDR_W-1:0]   node_wr_addr;
   logic                 node_rd_en;
   logic [NADDR_W-1:0]   node_rd_addr;
   logic [NODE_BITS-1:0] node_rd_raw;
   node_type             node_q;
   logic                 feat_wr_en;
   logic [FEAT_W-1:0]    feat_wr_addr;
   logic                 feat_rd_en;
   logic [FEAT_W-1:0]    feat_rd_addr;
   logic [15:0]          feat_rd_data;
   logic [15:0]          feat_value;
   logic                 below;
   logic [7:0]           child;
   logic                 tree_end;
   logic [CNT_W-1:0]     tree_next;
   logic [CNT_W-1:0]     scan_votes;

   assign node_q       = node_type'(node_rd_raw);
   assign node_wr_addr = {TREE_W'(q_entry.tree), NODE_W'(q_entry.node)};
   assign feat_wr_addr = FEAT_W'(q_entry.feat_idx);
   assign feat_rd_addr = FEAT_W'(node_q.feat);
   assign tree_next    = tree_ff + CNT_W'(1);
   assign scan_votes   = counts_ff[scan_ff];

   // Inner node test: the integer feature is taken as Q16.8 and compared exactly.
   assign feat_value = feat_ok_ff ? feat_rd_data : 16'h0000;
   assign below      = $signed({feat_value, 8'h00}) < node_ff.cut;
   assign child      = below ? node_ff.lo : node_ff.hi;

   rfc_ram #(
      .WIDTH(NODE_BITS),
      .DEPTH(1 << NADDR_W)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (node_wr_en),
      .wr_addr(node_wr_addr),
      .wr_data(q_entry.node_data),
      .rd_en  (node_rd_en),
      .rd_addr(node_rd_addr),
      .rd_data(node_rd_raw)
   );

   rfc_ram #(
      .WIDTH(16),
      .DEPTH(MAX_FEATURES)
   ) u_feat_ram (
      .clock  (clock),
      .wr_en  (feat_wr_en),
      .wr_addr(feat_wr_addr),
      .wr_data(q_entry.feat_val),
      .rd_en  (feat_rd_en),
      .rd_addr(feat_rd_addr),
      .rd_data(feat_rd_data)
   );

   // Sequencer: executes queued writes, walks the trees of a classify word, scans the votes and posts the result.
   always_comb begin
      state_in      = state_ff;
      tree_in       = tree_ff;
      trees_in      = trees_ff;
      visits_in     = visits_ff;
      node_in       = node_ff;
      feat_ok_in    = feat_ok_ff;
      err_in        = err_ff;
      counts_in     = counts_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_votes_in = best_votes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_class_in  = rsp_class_ff;
      rsp_votes_in  = rsp_votes_ff;
      rsp_err_in    = rsp_err_ff;
      q_pop         = 1'b0;
      node_wr_en    = 1'b0;
      feat_wr_en    = 1'b0;
      node_rd_en    = 1'b0;
      node_rd_addr  = '0;
      feat_rd_en    = 1'b0;
      tree_end      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_entry.op)
                  CMD_NODE:    node_wr_en = 1'b1;
                  CMD_FEATURE: feat_wr_en = 1'b1;
                  CMD_CLASSIFY: begin
                     for (int c = 0; c < NUM_CLASSES; c++) begin
                        counts_in[c] = '0;
                     end
                     err_in    = 1'b0;
                     tree_in   = '0;
                     visits_in = '0;
                     scan_in   = '0;
                     trees_in  = (32'(num_trees) > MAX_TREES) ?
                                 CNT_W'(MAX_TREES) : CNT_W'(num_trees);
                     if (num_trees == 7'd0) begin
                        state_in = S_SCAN;
                     end else begin
                        node_rd_en = 1'b1;
                        state_in   = S_NODE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_NODE: begin
            if (node_q.leaf) begin
               if (32'(node_q.cls) < NUM_CLASSES) begin
                  counts_in[CLASS_W'(node_q.cls)] =
                     counts_ff[CLASS_W'(node_q.cls)] + CNT_W'(1);
               end
               tree_end = 1'b1;
            end else begin
               node_in    = node_q;
               feat_ok_in = (32'(node_q.feat) < MAX_FEATURES);
               feat_rd_en = (32'(node_q.feat) < MAX_FEATURES);
               state_in   = S_FEAT;
            end
         end

         S_FEAT: begin
            if ((32'(child) >= MAX_NODES) || (visits_ff == NODE_W'(MAX_NODES - 1))) begin
               err_in   = 1'b1;
               tree_end = 1'b1;
            end else begin
               visits_in    = visits_ff + NODE_W'(1);
               node_rd_en   = 1'b1;
               node_rd_addr = {TREE_W'(tree_ff), NODE_W'(child)};
               state_in     = S_NODE;
            end
         end

         S_SCAN: begin
            if ((scan_ff == '0) || (scan_votes > best_votes_ff)) begin
               best_in       = scan_ff;
               best_votes_in = scan_votes;
            end
            scan_in = scan_ff + CLASS_W'(1);
            if (scan_ff == CLASS_W'(NUM_CLASSES - 1)) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = 4'(best_ff);
               rsp_votes_in = (32'(best_votes_ff) > VOTE_SAT) ?
                              7'(VOTE_SAT) : 7'(best_votes_ff);
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Move on to the next tree, or to the vote scan after the last one.
      if (tree_end) begin
         visits_in = '0;
         tree_in   = tree_next;
         if (tree_next == trees_ff) begin
            scan_in  = '0;
            state_in = S_SCAN;
         end else begin
            node_rd_en   = 1'b1;
            node_rd_addr = {TREE_W'(tree_next), NODE_W'(0)};
            state_in     = S_NODE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tree_ff       <= tree_in;
      trees_ff      <= trees_in;
      visits_ff     <= visits_in;
      node_ff       <= node_in;
      feat_ok_ff    <= feat_ok_in;
      err_ff        <= err_in;
      counts_ff     <= counts_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_votes_ff <= best_votes_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_votes_ff  <= rsp_votes_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_empty           = !rsp_valid_ff;
   assign rsp_predicted_class = rsp_class_ff;
   assign rsp_winning_votes   = rsp_votes_ff;
   assign rsp_walk_error      = rsp_err_ff;

endmodule

`default_nettype wire

// ----- bench/forest_vote_checker.sv -----
module forest_vote_checker
   import rfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_cmd,
   input  logic [5:0]         req_tree_index,
   input  logic [7:0]         req_node_index,
   input  logic               req_is_leaf,
   input  logic [5:0]         req_split_feature,
   input  logic signed [23:0] req_threshold,
   input  logic [7:0]         req_left_child,
   input  logic [7:0]         req_right_child,
   input  logic [3:0]         req_leaf_class,
   input  logic [5:0]         req_feature_index,
   input  logic signed [15:0] req_feature_value,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [3:0]         rsp_predicted_class,
   input  logic [6:0]         rsp_winning_votes,
   input  logic               rsp_walk_error,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [6:0]         csr_num_trees,
   output int                 pending,
   output int                 failures
);

   // One predicted result word.
   typedef struct packed {
      logic [3:0] cls;
      logic [6:0] votes;
      logic       err;
   } verdict_type;

   // Shadow copy of the forest, the observation and the tree count.
   node_type           forest [DEF_MAX_TREES][DEF_MAX_NODES];
   logic signed [15:0] features [DEF_MAX_FEATURES];
   logic [6:0]         trees_cfg = 7'd1;

   // Classifications accepted whose result word has not been popped yet.
   verdict_type votes_due [$];

   // Walks every tree in use and returns the majority class, its votes and the error flag.
   function automatic verdict_type tally_forest();
      int          tally [DEF_NUM_CLASSES];
      int          in_use;
      int          at;
      int          best;
      bit          done;
      node_type    nd;
      verdict_type v;
      v = '0;
      foreach (tally[c]) tally[c] = 0;
      in_use = (trees_cfg > DEF_MAX_TREES) ? DEF_MAX_TREES : int'(trees_cfg);
      for (int t = 0; t < in_use; t++) begin
         at = 0;
         done = 1'b0;
         // A walk that has not met a leaf after one visit per node is abandoned.
         for (int hop = 0; hop < DEF_MAX_NODES && !done; hop++) begin
            nd = forest[t][at];
            if (nd.leaf) begin
               // Leaves naming a class beyond the last one cast no vote.
               if (nd.cls < DEF_NUM_CLASSES) tally[nd.cls]++;
               done = 1'b1;
            end else if (int'(features[nd.feat]) * 256 < int'($signed(nd.cut))) begin
               at = nd.lo;
            end else begin
               at = nd.hi;
            end
         end
         if (!done) v.err = 1'b1;
      end
      // Strictly greater wins, so ties stay with the lowest class.
      best = 0;
      for (int c = 1; c < DEF_NUM_CLASSES; c++) begin
         if (tally[c] > tally[best]) best = c;
      end
      v.cls = 4'(best);
      v.votes = 7'((tally[best] > VOTE_SAT) ? VOTE_SAT : tally[best]);
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         trees_cfg = 7'd1;
         votes_due.delete();
      end else begin
         // Popped words are matched first so that a word arriving with nothing due is caught.
         if (rsp_pop && !rsp_empty) begin
            if (votes_due.size() == 0) begin
               failures++;
               $error("result word with no classification due: class %0d, votes %0d, error %0d",
                      rsp_predicted_class, rsp_winning_votes, rsp_walk_error);
            end else begin
               want = votes_due.pop_front();
               if (rsp_predicted_class !== want.cls) begin
                  failures++;
                  $error("predicted_class: expected %0d, got %0d", want.cls, rsp_predicted_class);
               end
               if (rsp_winning_votes !== want.votes) begin
                  failures++;
                  $error("winning_votes: expected %0d, got %0d", want.votes, rsp_winning_votes);
               end
               if (rsp_walk_error !== want.err) begin
                  failures++;
                  $error("walk_error: expected %0d, got %0d", want.err, rsp_walk_error);
               end
            end
         end

         if (csr_valid && csr_ready) trees_cfg = csr_num_trees;

         // Each accepted word updates the shadow state or queues a prediction.
         if (req_push && !req_full) begin
            case (req_cmd)
               CMD_NODE: begin
                  forest[req_tree_index][req_node_index] = '{leaf: req_is_leaf,
                                                              feat: req_split_feature,
                                                              cls: req_leaf_class,
                                                              cut: req_threshold,
                                                              lo: req_left_child,
                                                              hi: req_right_child};
               end
               CMD_FEATURE: begin
                  features[req_feature_index] = req_feature_value;
               end
               CMD_CLASSIFY: begin
                  votes_due.insert(votes_due.size(), tally_forest());
               end
               default: begin
               end
            endcase
         end
      end
      pending = votes_due.size();
   end

endmodule

// ----- bench/tb_random_forest_classifier.sv -----
module tb_random_forest_classifier;
   import rfc_pkg::*;

   localparam int         CYCLE_LIMIT   = 3_000_000;
   localparam int         PHASE_WORDS   = 160;
   localparam int         SETTLE_CYCLES = 32;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   entry_type  req_word = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [3:0] rsp_predicted_class;
   logic [6:0] rsp_winning_votes;
   logic       rsp_walk_error;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_num_trees = 7'd1;

   int pending;
   int failures;

   // Stimulus bookkeeping: which nodes hold data, the current observation, the tree count.
   bit                 node_written [DEF_MAX_TREES][DEF_MAX_NODES];
   logic signed [15:0] feature_shadow [DEF_MAX_FEATURES];
   int                 trees_set = 1;
   bit                 push_steady = 1'b0;
   bit                 drain_steady = 1'b0;
   int                 words_sent = 0;
   int                 classify_sent = 0;
   int                 settings_done = 0;
   int unsigned        cycle_count = 0;

   always #6 clock = ~clock;

   random_forest_classifier dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_cmd             (req_word.op),
      .req_tree_index      (req_word.tree),
      .req_node_index      (req_word.node),
      .req_is_leaf         (req_word.node_data.leaf),
      .req_split_feature   (req_word.node_data.feat),
      .req_threshold       (req_word.node_data.cut),
      .req_left_child      (req_word.node_data.lo),
      .req_right_child     (req_word.node_data.hi),
      .req_leaf_class      (req_word.node_data.cls),
      .req_feature_index   (req_word.feat_idx),
      .req_feature_value   (req_word.feat_val),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_winning_votes   (rsp_winning_votes),
      .rsp_walk_error      (rsp_walk_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_trees       (csr_num_trees)
   );

   forest_vote_checker vote_check (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_cmd             (req_word.op),
      .req_tree_index      (req_word.tree),
      .req_node_index      (req_word.node),
      .req_is_leaf         (req_word.node_data.leaf),
      .req_split_feature   (req_word.node_data.feat),
      .req_threshold       (req_word.node_data.cut),
      .req_left_child      (req_word.node_data.lo),
      .req_right_child     (req_word.node_data.hi),
      .req_leaf_class      (req_word.node_data.cls),
      .req_feature_index   (req_word.feat_idx),
      .req_feature_value   (req_word.feat_val),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_winning_votes   (rsp_winning_votes),
      .rsp_walk_error      (rsp_walk_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_trees       (csr_num_trees),
      .pending             (pending),
      .failures            (failures)
   );

   // Idle cycles before the next word; steady stretches switch on and off now and then.
   function automatic int draw_gap(inout bit steady);
      if ($urandom_range(0, 29) == 0) steady = !steady;
      return steady ? 0 : int'($urandom_range(0, 18));
   endfunction

   // A word with every field random; callers overwrite the fields that matter.
   function automatic entry_type noise_word();
      logic [95:0] raw;
      raw = {$urandom(), $urandom(), $urandom()};
      return entry_type'(raw[$bits(entry_type)-1:0]);
   endfunction

   function automatic entry_type op_word(logic [1:0] op);
      entry_type w;
      w = noise_word();
      w.op = op;
      return w;
   endfunction

   function automatic entry_type node_word(int t, int n, bit leaf, int feat, int cut,
                                           int lo, int hi, int cls);
      entry_type w;
      w = op_word(CMD_NODE);
      w.tree = 6'(t);
      w.node = 8'(n);
      w.node_data.leaf = leaf;
      w.node_data.feat = 6'(feat);
      w.node_data.cut = 24'(cut);
      w.node_data.lo = 8'(lo);
      w.node_data.hi = 8'(hi);
      w.node_data.cls = 4'(cls);
      return w;
   endfunction

   function automatic entry_type feature_word(int idx, int val);
      entry_type w;
      w = op_word(CMD_FEATURE);
      w.feat_idx = 6'(idx);
      w.feat_val = 16'(val);
      return w;
   endfunction

   // Sends one word, holding push high across back-to-back words.
   task automatic send_word(input entry_type w);
      int gap;
      gap = draw_gap(push_steady);
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_word <= w;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (w.op == CMD_NODE) node_written[w.tree][w.node] = 1'b1;
      if (w.op == CMD_FEATURE) feature_shadow[w.feat_idx] = w.feat_val;
      if (w.op == CMD_CLASSIFY) classify_sent++;
      words_sent++;
   endtask

   // Stops pushing, waits for every result, then lets queued writes drain.
   task automatic quiesce();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_tree_count(input logic [6:0] count);
      quiesce();
      csr_num_trees <= count;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      trees_set = count;
      settings_done++;
   endtask

   // Node writes keep trees acyclic but for the case below: inner nodes only point to higher, written nodes.
   // Trees 0 and 1 occasionally get a node that points to itself, so walks there can run out.
   task automatic random_node_write();
      entry_type w;
      int        in_use;
      int        t;
      int        n;
      int        above [$];
      in_use = (trees_set > DEF_MAX_TREES) ? DEF_MAX_TREES : trees_set;
      t = (in_use == 0) ? $urandom_range(0, DEF_MAX_TREES - 1) : $urandom_range(0, in_use - 1);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEF_MAX_NODES - 1)
                                       : $urandom_range(0, 15);
      for (int i = n + 1; i < DEF_MAX_NODES; i++) begin
         if (node_written[t][i]) above.insert(above.size(), i);
      end
      w = op_word(CMD_NODE);
      w.tree = 6'(t);
      w.node = 8'(n);
      if (t < 2 && $urandom_range(0, 39) == 0) begin
         w.node_data.leaf = 1'b0;
         w.node_data.lo = 8'(n);
         w.node_data.hi = 8'(n);
      end else if (above.size() > 0 && $urandom_range(0, 2) != 0) begin
         w.node_data.leaf = 1'b0;
         w.node_data.lo = 8'(above[$urandom_range(0, above.size() - 1)]);
         w.node_data.hi = 8'(above[$urandom_range(0, above.size() - 1)]);
         // Now and then the cut sits exactly on the stored feature value.
         if ($urandom_range(0, 4) == 0) begin
            w.node_data.cut = 24'(int'(feature_shadow[w.node_data.feat]) * 256);
         end
      end else begin
         w.node_data.leaf = 1'b1;
         // Most leaves name a real class; the rest keep a random, possibly unused one.
         if ($urandom_range(0, 5) != 0) begin
            w.node_data.cls = 4'($urandom_range(0, DEF_NUM_CLASSES - 1));
         end
      end
      send_word(w);
   endtask

   // Results are popped after a random hold that follows each popped result.
   initial begin : result_drain
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
         end else begin
            rsp_pop <= 1'b1;
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) hold = draw_gap(drain_steady);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [6:0] settings [6];
      int         sent;
      int         pick;
      settings = '{7'd64, 7'd127, 7'd0, 7'd1, 7'($urandom_range(2, 20)),
                   7'($urandom_range(1, 127))};
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Fill the whole observation and give every tree a leaf root, so no walk reads junk.
      for (int f = 0; f < DEF_MAX_FEATURES; f++) begin
         send_word(feature_word(f, $urandom_range(0, 65535)));
      end
      for (int t = 0; t < DEF_MAX_TREES; t++) begin
         send_word(node_word(t, 0, 1'b1, 0, 0, 0, 0, t % DEF_NUM_CLASSES));
      end

      // Directed cases on tree 0 with the tree count left at its reset value.
      send_word(op_word(CMD_CLASSIFY));
      send_word(feature_word(5, 32767));
      send_word(feature_word(6, -32768));
      send_word(node_word(0, 2, 1'b1, 0, 0, 0, 0, 9));
      send_word(node_word(0, 3, 1'b1, 0, 0, 0, 0, 4));
      // Largest feature equal to the cut goes right.
      send_word(node_word(0, 0, 1'b0, 5, 32767 * 256, 2, 3, 0));
      send_word(op_word(CMD_CLASSIFY));
      // Largest cut sends the largest feature left.
      send_word(node_word(0, 0, 1'b0, 5, 8388607, 2, 3, 0));
      send_word(op_word(CMD_CLASSIFY));
      // Smallest feature equal to the smallest cut goes right.
      send_word(node_word(0, 0, 1'b0, 6, -8388608, 2, 3, 0));
      send_word(op_word(CMD_CLASSIFY));
      // A leaf with an unused class casts no vote.
      send_word(node_word(0, 3, 1'b1, 0, 0, 0, 0, 15));
      send_word(op_word(CMD_CLASSIFY));
      // A node pointing to itself makes the walk run out.
      send_word(node_word(0, 1, 1'b0, 0, 0, 1, 1, 0));
      send_word(node_word(0, 0, 1'b0, 6, -8388608, 1, 1, 0));
      send_word(op_word(CMD_CLASSIFY));
      send_word(node_word(0, 1, 1'b1, 0, 0, 0, 0, 3));
      send_word(node_word(0, 0, 1'b1, 0, 0, 0, 0, 7));
      send_word(op_word(CMD_UNUSED));
      send_word(op_word(CMD_CLASSIFY));
      // Two trees voting 7 and 1 tie, and the lower class wins.
      set_tree_count(7'd2);
      send_word(op_word(CMD_CLASSIFY));
      set_tree_count(7'd0);
      send_word(op_word(CMD_CLASSIFY));

      // Random phases, one per tree count.
      foreach (settings[p]) begin
         set_tree_count(settings[p]);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               random_node_write();
               sent++;
            end else if (pick < 65) begin
               send_word(feature_word($urandom_range(0, DEF_MAX_FEATURES - 1),
                                      $urandom_range(0, 65535)));
               sent++;
            end else if (pick < 95) begin
               send_word(op_word(CMD_CLASSIFY));
               sent++;
            end else begin
               send_word(op_word(CMD_UNUSED));
            end
         end
      end

      quiesce();
      $display("Sent %0d words, %0d of them classifications, under %0d tree-count settings.",
               words_sent, classify_sent, settings_done);
      if (failures == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
